// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define IFP_ASSERT_RST(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ifp assertion failed");

// Clocked assertion, active during reset as well.
`define IFP_ASSERT(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ifp assertion failed");

`endif

// ===== rtl/core/ifp_pkg.sv =====
`timescale 1ns / 1ps

package ifp_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LIMIT_W  = 15;
    localparam int RUN_W    = 8;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [LIMIT_W-1:0] VOLT_LIMIT_RST    = 15'd27153;
    localparam logic [LIMIT_W-1:0] CURR_LIMIT_RST    = 15'd13323;
    localparam logic [RUN_W-1:0]   VOLT_COUNT_RST    = 8'd10;
    localparam logic [RUN_W-1:0]   CURR_COUNT_RST    = 8'd10;
    localparam logic [RUN_W-1:0]   REVERSE_COUNT_RST = 8'd200;
    localparam logic [RUN_W-1:0]   RUN_MAX           = 8'd255;

    // register index, taken from paddr[4:2]
    localparam logic [2:0] REG_VOLT_LIMIT    = 3'd0;
    localparam logic [2:0] REG_CURR_LIMIT    = 3'd1;
    localparam logic [2:0] REG_VOLT_COUNT    = 3'd2;
    localparam logic [2:0] REG_CURR_COUNT    = 3'd3;
    localparam logic [2:0] REG_REVERSE_COUNT = 3'd4;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_STOP   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [1:0] KIND_NONE      = 2'd0;
    localparam logic [1:0] KIND_OVER_CURR = 2'd1;
    localparam logic [1:0] KIND_OVER_VOLT = 2'd2;
    localparam logic [1:0] KIND_REVERSE   = 2'd3;

    typedef struct packed {
        logic       tripped_now;
        logic [1:0] fault_kind;
        logic       fault_active;
    } status_t;

endpackage

// ===== rtl/core/inverter_fault_protection_core.sv =====
`timescale 1ns / 1ps
// Inverter fault protection: persistence-filtered over-voltage, over-current
// and reverse-power trip with a fault latch.
// Input beats (s_*): tuser carries the action (sample, stop, clear fault),
// tdata carries voltage and current samples. Every input beat gives exactly
// one output beat (m_*) with the fault latch, the recorded cause and a flag
// for a trip on that beat.
// An accepted beat goes to the input register, its result to the result
// register. Throughput: one beat per cycle while the output is not stalled,
// set by the single compare-and-count stage in between. The input side
// keeps accepting while a result waits in the output register, as long as
// the input register can move on; when m_tready is low and both registers
// hold data, s_tready drops until the result is taken. Write limits over
// the APB port only while no beat is in flight; the block does not enforce
// this. Reset (aresetn low, synchronous) empties both registers, clears the
// run counters and the fault latch and restores the default limits.

module inverter_fault_protection_core
    import ifp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [15:0] voltage_sample, [31:16] current_sample
    input  logic [1:0]        s_tuser,   // [1:0] action
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [0] fault_active, [2:1] fault_kind,
                                         // [3] tripped_now, [7:4] zero
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [LIMIT_W-1:0] volt_limit_reg;
    logic [LIMIT_W-1:0] curr_limit_reg;
    logic [RUN_W-1:0]   volt_count_reg;
    logic [RUN_W-1:0]   curr_count_reg;
    logic [RUN_W-1:0]   reverse_count_reg;

    logic                in_valid_reg;
    logic [1:0]          in_action_reg;
    logic [SAMPLE_W-1:0] in_volt_reg;
    logic [SAMPLE_W-1:0] in_curr_reg;

    logic [RUN_W-1:0] volt_run_reg,    volt_run_next;
    logic [RUN_W-1:0] curr_run_reg,    curr_run_next;
    logic [RUN_W-1:0] reverse_run_reg, reverse_run_next;
    logic             latch_reg,       latch_next;
    logic [1:0]       cause_reg,       cause_next;
    logic             tripped;

    logic    out_valid_reg;
    status_t out_status_reg;

    logic                pipe_adv;
    logic                cfg_wr;
    logic [SAMPLE_W-1:0] volt_mag;
    logic [SAMPLE_W-1:0] curr_mag;
    logic                volt_neg, volt_pos, curr_neg, curr_pos;
    logic                volt_exceed, curr_exceed, reverse;
    logic [RUN_W-1:0]    volt_adv, curr_adv, reverse_adv;

    function automatic logic [RUN_W-1:0] run_step(logic [RUN_W-1:0] run, logic cond);
        logic [RUN_W-1:0] res;
        if (!cond) begin
            res = '0;
        end else if (run == RUN_MAX) begin
            res = RUN_MAX;
        end else begin
            res = run + RUN_W'(1);
        end
        return res;
    endfunction

    assign pipe_adv = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || pipe_adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_status_reg};
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volt_limit_reg    <= VOLT_LIMIT_RST;
            curr_limit_reg    <= CURR_LIMIT_RST;
            volt_count_reg    <= VOLT_COUNT_RST;
            curr_count_reg    <= CURR_COUNT_RST;
            reverse_count_reg <= REVERSE_COUNT_RST;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_VOLT_LIMIT:    volt_limit_reg    <= pwdata[LIMIT_W-1:0];
                REG_CURR_LIMIT:    curr_limit_reg    <= pwdata[LIMIT_W-1:0];
                REG_VOLT_COUNT:    volt_count_reg    <= pwdata[RUN_W-1:0];
                REG_CURR_COUNT:    curr_count_reg    <= pwdata[RUN_W-1:0];
                REG_REVERSE_COUNT: reverse_count_reg <= pwdata[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_VOLT_LIMIT:    prdata = DATA_W'(volt_limit_reg);
            REG_CURR_LIMIT:    prdata = DATA_W'(curr_limit_reg);
            REG_VOLT_COUNT:    prdata = DATA_W'(volt_count_reg);
            REG_CURR_COUNT:    prdata = DATA_W'(curr_count_reg);
            REG_REVERSE_COUNT: prdata = DATA_W'(reverse_count_reg);
            default:           prdata = '0;
        endcase
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= s_tuser;
            in_volt_reg   <= s_tdata[15:0];
            in_curr_reg   <= s_tdata[31:16];
        end
    end

    // compare and count
    always_comb begin
        volt_mag    = in_volt_reg[SAMPLE_W-1] ? (~in_volt_reg + SAMPLE_W'(1)) : in_volt_reg;
        curr_mag    = in_curr_reg[SAMPLE_W-1] ? (~in_curr_reg + SAMPLE_W'(1)) : in_curr_reg;
        volt_neg    = in_volt_reg[SAMPLE_W-1];
        curr_neg    = in_curr_reg[SAMPLE_W-1];
        volt_pos    = !volt_neg && (in_volt_reg != '0);
        curr_pos    = !curr_neg && (in_curr_reg != '0);
        volt_exceed = volt_mag > {1'b0, volt_limit_reg};
        curr_exceed = curr_mag > {1'b0, curr_limit_reg};
        reverse     = (volt_neg && curr_pos) || (volt_pos && curr_neg);

        volt_adv    = run_step(volt_run_reg, volt_exceed);
        curr_adv    = run_step(curr_run_reg, curr_exceed);
        reverse_adv = run_step(reverse_run_reg, reverse);

        volt_run_next    = volt_run_reg;
        curr_run_next    = curr_run_reg;
        reverse_run_next = reverse_run_reg;
        latch_next       = latch_reg;
        cause_next       = cause_reg;
        tripped          = 1'b0;

        case (in_action_reg)
            ACT_SAMPLE: begin
                volt_run_next    = volt_adv;
                curr_run_next    = curr_adv;
                reverse_run_next = reverse_adv;
                if (curr_adv >= curr_count_reg) begin
                    curr_run_next = '0;
                    latch_next    = 1'b1;
                    cause_next    = KIND_OVER_CURR;
                    tripped       = 1'b1;
                end
                if (volt_adv >= volt_count_reg) begin
                    volt_run_next = '0;
                    latch_next    = 1'b1;
                    cause_next    = KIND_OVER_VOLT;
                    tripped       = 1'b1;
                end
                if (reverse_adv >= reverse_count_reg) begin
                    reverse_run_next = '0;
                    latch_next       = 1'b1;
                    cause_next       = KIND_REVERSE;
                    tripped          = 1'b1;
                end
            end
            ACT_STOP: begin
                volt_run_next    = '0;
                curr_run_next    = '0;
                reverse_run_next = '0;
            end
            ACT_CLEAR: begin
                latch_next = 1'b0;
                cause_next = KIND_NONE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volt_run_reg    <= '0;
            curr_run_reg    <= '0;
            reverse_run_reg <= '0;
            latch_reg       <= 1'b0;
            cause_reg       <= KIND_NONE;
        end else if (pipe_adv) begin
            volt_run_reg    <= volt_run_next;
            curr_run_reg    <= curr_run_next;
            reverse_run_reg <= reverse_run_next;
            latch_reg       <= latch_next;
            cause_reg       <= cause_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_adv) begin
            out_status_reg.fault_active <= latch_next;
            out_status_reg.fault_kind   <= cause_next;
            out_status_reg.tripped_now  <= tripped;
        end
    end

endmodule

// ===== rtl/core/ifp_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ifp_checker
    import ifp_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    logic out_active;
    logic out_trip;
    logic out_has_cause;

    assign out_active    = m_tdata[0];
    assign out_trip      = m_tdata[3];
    assign out_has_cause = (m_tdata[2:1] != KIND_NONE);

    // a trip always leaves the latch set
    `IFP_ASSERT_RST(a_trip_sets_latch, aclk, aresetn, m_tvalid |-> (!out_trip || out_active))
    // latch and recorded cause move together
    `IFP_ASSERT_RST(a_latch_has_cause, aclk, aresetn, m_tvalid |-> (out_active == out_has_cause))
    // hold a stalled result beat
    `IFP_ASSERT_RST(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // reset empties the pipeline and opens the input
    `IFP_ASSERT(a_reset_empty, aclk, !aresetn |=> (!m_tvalid && s_tready))

endmodule

bind inverter_fault_protection_core ifp_checker u_ifp_checker (.*);
